// ----- design/bfr_pkg.sv -----
// Shared types and constants for the byte FIFO with rewind.
package bfr_pkg;

    localparam int BFR_DEPTH = 256;

    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_POP    = 3'd1;
    localparam logic [2:0] ACT_CLEAR  = 3'd2;
    localparam logic [2:0] ACT_SAVE   = 3'd3;
    localparam logic [2:0] ACT_REWIND = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] push_byte;
    } t_req;

    typedef struct packed {
        logic       status;
        logic [7:0] pop_byte;
        logic       is_full;
        logic       is_empty;
        logic [8:0] occupancy;
    } t_rsp;

    typedef struct packed {
        logic       status;
        logic       is_pop;
        logic       is_full;
        logic       is_empty;
        logic [8:0] occupancy;
    } t_meta;

endpackage

// ----- design/bfr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bfr_pkg::BFR_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/bfr_ptr.sv -----
// Pointer, flag and checkpoint state of the byte FIFO with rewind.
module bfr_ptr #(
    parameter int DEPTH = bfr_pkg::BFR_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [2:0]               i_action,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    output bfr_pkg::t_meta           o_meta
);

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_wp, r_rp, r_saved;
    logic          r_full, r_popped;
    logic [AW-1:0] n_wp, n_rp, n_saved;
    logic          n_full, n_popped;
    logic [AW-1:0] wp_inc, rp_inc;
    logic          empty_now, refused, do_push, do_pop;
    logic [OW-1:0] occ;
    logic [OW+8:0] occ_ext;

    assign wp_inc    = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign rp_inc    = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
    assign empty_now = !r_full && (r_wp == r_rp);

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_saved  = r_saved;
        n_full   = r_full;
        n_popped = r_popped;
        refused  = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        unique case (i_action)
            bfr_pkg::ACT_PUSH: begin
                if (r_full) begin
                    refused = 1'b1;
                end else begin
                    do_push = 1'b1;
                    n_wp    = wp_inc;
                    n_full  = (wp_inc == r_rp);
                end
            end
            bfr_pkg::ACT_POP: begin
                if (empty_now) begin
                    refused = 1'b1;
                end else begin
                    do_pop   = 1'b1;
                    n_rp     = rp_inc;
                    n_full   = 1'b0;
                    n_popped = 1'b1;
                end
            end
            bfr_pkg::ACT_CLEAR: begin
                n_wp     = '0;
                n_rp     = '0;
                n_saved  = '0;
                n_full   = 1'b0;
                n_popped = 1'b0;
            end
            bfr_pkg::ACT_SAVE: begin
                n_saved  = r_rp;
                n_popped = 1'b0;
            end
            bfr_pkg::ACT_REWIND: begin
                if (r_popped) begin
                    n_rp     = r_saved;
                    n_full   = (r_saved == r_wp);
                    n_popped = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (n_full) begin
            occ = OW'(DEPTH);
        end else if (n_wp >= n_rp) begin
            occ = OW'(n_wp) - OW'(n_rp);
        end else begin
            occ = OW'(n_wp) + OW'(DEPTH) - OW'(n_rp);
        end
    end

    assign occ_ext = (OW + 9)'(occ);

    assign o_we    = i_accept && do_push;
    assign o_waddr = r_wp;
    assign o_re    = i_accept && do_pop;
    assign o_raddr = r_rp;

    assign o_meta.status    = refused;
    assign o_meta.is_pop    = do_pop;
    assign o_meta.is_full   = n_full;
    assign o_meta.is_empty  = (occ == '0);
    assign o_meta.occupancy = occ_ext[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_saved  <= '0;
            r_full   <= 1'b0;
            r_popped <= 1'b0;
        end else if (i_accept) begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_saved  <= n_saved;
            r_full   <= n_full;
            r_popped <= n_popped;
        end
    end

    a_full_meets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wp == r_rp))
        else $error("full flag set while pointers differ");

    a_refused_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_action == bfr_pkg::ACT_PUSH && r_full) |=> $stable(r_wp))
        else $error("refused push moved the write pointer");

    a_pop_unfull : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_action == bfr_pkg::ACT_POP && !empty_now) |=> !r_full)
        else $error("pop left the FIFO full");

    a_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_action == bfr_pkg::ACT_CLEAR) |=>
        (r_wp == '0 && r_rp == '0 && !r_full && !r_popped))
        else $error("clear did not reset the pointers");

endmodule

// ----- design/byte_fifo_with_rewind_unit.sv -----
// Top level of the byte FIFO with rewind: request handshake, RAM and result stage.
// Accepted requests pass the metadata/RAM-read registers, then the result register.
// Throughput: one request per cycle unless stalled; the pointer update finishes in
// the cycle of acceptance and the byte RAM's single read port is read once per pop.
// Reset (synchronous, active low) empties the FIFO and drops any request in flight.
// The byte RAM itself is not cleared; entries hold nothing meaningful until written.
module byte_fifo_with_rewind_unit #(
    parameter int DEPTH = bfr_pkg::BFR_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bfr_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output bfr_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(DEPTH);

    logic           accept, out_blocked, advance;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_rdata;
    bfr_pkg::t_meta meta;

    logic           r_pend, r_out_valid;
    logic           n_pend, n_out_valid;
    bfr_pkg::t_meta r_meta;
    bfr_pkg::t_rsp  r_rsp;

    assign out_blocked = r_out_valid && i_stall;
    assign advance     = r_pend && !out_blocked;
    assign o_stall     = r_pend && out_blocked;
    assign accept      = i_valid && !o_stall;

    bfr_ptr #(.DEPTH(DEPTH)) u_ptr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_req.action),
        .o_we     (ram_we),
        .o_waddr  (ram_waddr),
        .o_re     (ram_re),
        .o_raddr  (ram_raddr),
        .o_meta   (meta)
    );

    bfr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.push_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_pend = r_pend;
        if (accept) begin
            n_pend = 1'b1;
        end else if (advance) begin
            n_pend = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meta <= meta;
        end
        if (advance) begin
            r_rsp.status    <= r_meta.status;
            r_rsp.pop_byte  <= r_meta.is_pop ? ram_rdata : 8'd0;
            r_rsp.is_full   <= r_meta.is_full;
            r_rsp.is_empty  <= r_meta.is_empty;
            r_rsp.occupancy <= r_meta.occupancy;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule
